// ===== design/lncch_pkg.sv =====
package lncch_pkg;

	localparam int CELL_SIZE = 4;
	localparam int MAX_CELLS = 1024;
	localparam int NUM_CENT  = 15;
	localparam int CELL_AREA = CELL_SIZE * CELL_SIZE;

	localparam int IDX_W     = 4;
	localparam int CNT_W     = $clog2(CELL_AREA + 1);
	localparam int PIX_W     = $clog2(CELL_AREA);
	localparam int CELL_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CELLNUM_W = 10;
	localparam int FRAC_W    = 17;
	localparam int COORD_W   = 16;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int DIST_W    = SQ_W + 2;

	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t LAST_CENT = IDX_W'(NUM_CENT - 1);

	typedef struct packed {
		logic [7:0] lightness;
		logic [7:0] chroma_a;
		logic [7:0] chroma_b;
	} pixel_t;

	typedef struct packed {
		logic [CELLNUM_W-1:0] cell_number;
		logic [IDX_W-1:0]     cluster_index;
		logic [FRAC_W-1:0]    bin_fraction;
		logic                 last_of_cell;
	} result_t;

	// one classified pixel between front and back
	typedef struct packed {
		logic vld;
		idx_t idx;
	} qent_t;

	typedef enum logic {
		F_IDLE,
		F_RUN
	} front_state_t;

	typedef enum logic {
		B_COUNT,
		B_EMIT
	} back_state_t;

	// centroids, 8.8 fixed point
	localparam logic [COORD_W-1:0] CENT_L [NUM_CENT] = '{
		16'd41297, 16'd36588, 16'd17377, 16'd23732, 16'd30764,
		16'd50040, 16'd10562, 16'd3076,  16'd58001, 16'd39594,
		16'd31022, 16'd22283, 16'd29135, 16'd20757, 16'd11524
	};
	localparam logic [COORD_W-1:0] CENT_A [NUM_CENT] = '{
		16'd32569, 16'd32939, 16'd32697, 16'd33271, 16'd32840,
		16'd32731, 16'd33295, 16'd33147, 16'd32657, 16'd33709,
		16'd35077, 16'd35126, 16'd27284, 16'd43533, 16'd35467
	};
	localparam logic [COORD_W-1:0] CENT_B [NUM_CENT] = '{
		16'd32924, 16'd32648, 16'd34791, 16'd35174, 16'd32521,
		16'd33112, 16'd33965, 16'd32529, 16'd34905, 16'd40059,
		16'd39279, 16'd25245, 16'd40401, 16'd38119, 16'd26215
	};

	typedef logic [FRAC_W-1:0] frac_tab_t [CELL_AREA+1];

	// count -> Q16 share of the cell, rounded half up
	function automatic frac_tab_t build_frac_tab();
		frac_tab_t t;
		for (int i = 0; i <= CELL_AREA; i++) begin
			t[i] = FRAC_W'((i * 65536 + CELL_AREA / 2) / CELL_AREA);
		end
		return t;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

// ===== design/lncch_front.sv =====
module lncch_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  lncch_pkg::pixel_t             pixel,
	input  logic [lncch_pkg::Q_CNT_W-1:0] q_count,
	output lncch_pkg::qent_t              q_wr
);
	import lncch_pkg::*;

	front_state_t state_q, state_d;
	pixel_t px_q;
	idx_t k_q;
	logic v_s1;
	idx_t k_s1;
	logic [SQ_W-1:0] sq_l_s1, sq_a_s1, sq_b_s1;
	logic [DIST_W-1:0] dist_sum, best_q;
	idx_t best_idx_q;
	logic take, accept;
	logic [COORD_W-1:0] d_l, d_a, d_b;
	logic [Q_CNT_W:0] q_used;

	function automatic logic [COORD_W-1:0] abs_diff(logic [7:0] p, logic [COORD_W-1:0] c);
		logic [COORD_W-1:0] pw;
		pw = {p, 8'h00};
		return (pw >= c) ? (pw - c) : (c - pw);
	endfunction

	always_comb begin
		q_used = {1'b0, q_count} + {{Q_CNT_W{1'b0}}, v_s1};
		full   = (state_q != F_IDLE) || (q_used >= (Q_CNT_W+1)'(Q_DEPTH));
		accept = push && !full;

		d_l = abs_diff(px_q.lightness, CENT_L[k_q]);
		d_a = abs_diff(px_q.chroma_a,  CENT_A[k_q]);
		d_b = abs_diff(px_q.chroma_b,  CENT_B[k_q]);

		dist_sum = DIST_W'(sq_l_s1) + DIST_W'(sq_a_s1) + DIST_W'(sq_b_s1);
		take = (k_s1 == '0) || (dist_sum < best_q);

		q_wr.vld = v_s1 && (k_s1 == LAST_CENT);
		q_wr.idx = take ? k_s1 : best_idx_q;

		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept)
					state_d = F_RUN;
			end
			F_RUN: begin
				if (k_q == LAST_CENT)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			v_s1    <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == F_RUN);
			if (accept)
				k_q <= '0;
			else if (state_q == F_RUN)
				k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			px_q <= pixel;
		if (state_q == F_RUN) begin
			k_s1    <= k_q;
			sq_l_s1 <= SQ_W'(d_l) * SQ_W'(d_l);
			sq_a_s1 <= SQ_W'(d_a) * SQ_W'(d_a);
			sq_b_s1 <= SQ_W'(d_b) * SQ_W'(d_b);
		end
		if (v_s1 && take) begin
			best_q     <= dist_sum;
			best_idx_q <= k_s1;
		end
	end

endmodule

// ===== design/lncch_fifo.sv =====
module lncch_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lncch_pkg::qent_t              wr,
	input  logic                          rd_pop,
	output lncch_pkg::qent_t              rd,
	output logic [lncch_pkg::Q_CNT_W-1:0] count
);
	import lncch_pkg::*;

	idx_t mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic do_pop;

	always_comb begin
		rd.vld = (cnt_q != '0);
		rd.idx = mem_q[rd_ptr_q];
		do_pop = rd_pop && rd.vld;
		count  = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr.vld)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + Q_CNT_W'(wr.vld) - Q_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.vld)
			mem_q[wr_ptr_q] <= wr.idx;
	end

endmodule

// ===== design/lncch_back.sv =====
module lncch_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lncch_pkg::qent_t    q_rd,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output lncch_pkg::result_t  result
);
	import lncch_pkg::*;

	back_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q [NUM_CENT];
	logic [PIX_W-1:0] pix_q;
	logic [CELL_W-1:0] cell_q;
	idx_t emit_k_q;
	result_t res_q;
	logic res_vld_q;
	logic slot_free, emit, cell_done;

	always_comb begin
		slot_free = !res_vld_q || pop;
		q_pop     = (state_q == B_COUNT) && q_rd.vld;
		emit      = (state_q == B_EMIT) && slot_free;
		cell_done = q_pop && (pix_q == PIX_W'(CELL_AREA - 1));
		empty     = !res_vld_q;
		result    = res_q;

		state_d = state_q;
		unique case (state_q)
			B_COUNT: begin
				if (cell_done)
					state_d = B_EMIT;
			end
			B_EMIT: begin
				if (emit && (emit_k_q == LAST_CENT))
					state_d = B_COUNT;
			end
			default: state_d = B_COUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_COUNT;
			pix_q     <= '0;
			cell_q    <= '0;
			emit_k_q  <= '0;
			res_vld_q <= 1'b0;
			for (int i = 0; i < NUM_CENT; i++)
				cnt_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cnt_q[q_rd.idx] <= cnt_q[q_rd.idx] + 1'b1;
				pix_q <= cell_done ? '0 : (pix_q + 1'b1);
				if (cell_done)
					emit_k_q <= '0;
			end
			// counts shift out toward index zero, zeros fill behind
			if (emit) begin
				for (int i = 0; i < NUM_CENT - 1; i++)
					cnt_q[i] <= cnt_q[i+1];
				cnt_q[NUM_CENT-1] <= '0;
				emit_k_q <= emit_k_q + 1'b1;
				if (emit_k_q == LAST_CENT)
					cell_q <= (cell_q == CELL_W'(MAX_CELLS - 1)) ? '0 : (cell_q + 1'b1);
			end
			if (emit)
				res_vld_q <= 1'b1;
			else if (pop)
				res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.cell_number   <= CELLNUM_W'(cell_q);
			res_q.cluster_index <= emit_k_q;
			res_q.bin_fraction  <= FRAC_TAB[cnt_q[0]];
			res_q.last_of_cell  <= (emit_k_q == LAST_CENT);
		end
	end

endmodule

// ===== design/lab_nearest_centroid_cell_histogram.sv =====
// channel  | direction | handshake                    | payload
// pixel    | in        | push, full  (push & !full)   | pixel_t  lightness, chroma_a, chroma_b
// result   | out       | empty, pop  (pop & !empty)   | result_t cell_number, cluster_index,
//          |           |                              |          bin_fraction, last_of_cell
// Front: accepts a pixel, then steps one centroid per cycle through three squarers.
// Back: bins one queued pixel per cycle, then emits 15 results per cell, one per free cycle.
// A 4-entry queue between them lets the front classify while the back emits.
// arst_n clears all control state and bin counts; no clearing pass.
// A stalled result port holds the back; the front stalls when busy or the queue is full.
module lab_nearest_centroid_cell_histogram (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lncch_pkg::pixel_t   pixel,
	output logic                empty,
	input  logic                pop,
	output lncch_pkg::result_t  result
);
	import lncch_pkg::*;

	qent_t q_wr, q_rd;
	logic q_pop;
	logic [Q_CNT_W-1:0] q_count;

	lncch_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.q_count (q_count),
		.q_wr    (q_wr)
	);

	lncch_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.rd_pop (q_pop),
		.rd     (q_rd),
		.count  (q_count)
	);

	lncch_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_rd   (q_rd),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

// ===== design/lncch_checker.sv =====
module lncch_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic                pop,
	input logic                empty,
	input lncch_pkg::result_t  result
);
	import lncch_pkg::*;

	// front is busy for the whole classification of a request
	a_busy_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("full not raised after accepted request");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.cluster_index <= LAST_CENT))
		else $error("cluster_index out of range");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.last_of_cell == (result.cluster_index == LAST_CENT)))
		else $error("last_of_cell does not match cluster_index");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

endmodule

bind lab_nearest_centroid_cell_histogram lncch_checker u_checker (.*);

// ===== bench/lab_nearest_centroid_cell_histogram_test.sv =====
`timescale 1ns / 100ps

module lab_nearest_centroid_cell_histogram_test;

	localparam int NUM_COLORS   = 15;
	localparam int AREA         = lncch_pkg::CELL_SIZE * lncch_pkg::CELL_SIZE;
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES  = 600;

	// Lab centroids, 8.8 fixed point: L, a, b
	localparam int COLOR_CENTERS [NUM_COLORS][3] = '{
		'{41297, 32569, 32924},
		'{36588, 32939, 32648},
		'{17377, 32697, 34791},
		'{23732, 33271, 35174},
		'{30764, 32840, 32521},
		'{50040, 32731, 33112},
		'{10562, 33295, 33965},
		'{ 3076, 33147, 32529},
		'{58001, 32657, 34905},
		'{39594, 33709, 40059},
		'{31022, 35077, 39279},
		'{22283, 35126, 25245},
		'{29135, 27284, 40401},
		'{20757, 43533, 38119},
		'{11524, 35467, 26215}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	lncch_pkg::pixel_t pixel = '0;
	logic empty;
	logic pop = 1'b0;
	lncch_pkg::result_t result;
	logic rx_hold = 1'b0;

	int bin_tally [NUM_COLORS];
	int color_hits [NUM_COLORS];
	int pixels_in_cell;
	int cell_index;
	lncch_pkg::result_t expected_bins [$];

	int error_count;
	int pixels_sent;
	int results_seen;
	int full_cycles;
	int ties_sent;
	int idle_pct;
	int stall_pct;

	lab_nearest_centroid_cell_histogram DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pixel(pixel),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint color_distance(lncch_pkg::pixel_t px, int k);
		longint dl;
		longint da;
		longint db;
		dl = longint'(px.lightness) * 256 - COLOR_CENTERS[k][0];
		da = longint'(px.chroma_a) * 256 - COLOR_CENTERS[k][1];
		db = longint'(px.chroma_b) * 256 - COLOR_CENTERS[k][2];
		return dl * dl + da * da + db * db;
	endfunction

	// strict compare keeps the lower index on a tie
	function automatic int nearest_color(lncch_pkg::pixel_t px);
		longint best_d;
		longint d;
		int best;
		best = 0;
		best_d = color_distance(px, 0);
		for (int k = 1; k < NUM_COLORS; k++) begin
			d = color_distance(px, k);
			if (d < best_d) begin
				best_d = d;
				best = k;
			end
		end
		return best;
	endfunction

	function automatic logic [7:0] near_byte(int c);
		int v;
		v = (c + 128) / 256 + int'($urandom_range(8)) - 4;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	function automatic lncch_pkg::pixel_t random_pixel();
		lncch_pkg::pixel_t px;
		int k;
		if ($urandom_range(99) < 55) begin
			k = $urandom_range(NUM_COLORS - 1);
			px.lightness = near_byte(COLOR_CENTERS[k][0]);
			px.chroma_a  = near_byte(COLOR_CENTERS[k][1]);
			px.chroma_b  = near_byte(COLOR_CENTERS[k][2]);
		end else begin
			px = 24'($urandom);
		end
		return px;
	endfunction

	task automatic predict_pixel(lncch_pkg::pixel_t px);
		lncch_pkg::result_t r;
		int k;
		int frac;
		k = nearest_color(px);
		color_hits[k]++;
		if (bin_tally[k] < 511)
			bin_tally[k]++;
		pixels_in_cell++;
		if (pixels_in_cell >= AREA) begin
			for (int c = 0; c < NUM_COLORS; c++) begin
				frac = (bin_tally[c] * 65536 + AREA / 2) / AREA;
				if (frac > 65536)
					frac = 65536;
				r.cell_number   = 10'(cell_index);
				r.cluster_index = 4'(c);
				r.bin_fraction  = 17'(frac);
				r.last_of_cell  = (c == NUM_COLORS - 1);
				expected_bins = {expected_bins, r};
				bin_tally[c] = 0;
			end
			pixels_in_cell = 0;
			cell_index = (cell_index + 1) % lncch_pkg::MAX_CELLS;
		end
	endtask

	task automatic check_result(lncch_pkg::result_t got);
		lncch_pkg::result_t want;
		results_seen++;
		if (expected_bins.size() == 0) begin
			error_count++;
			$display("%0t: unexpected result cell %0d cluster %0d fraction %0d last %0b",
				$time, got.cell_number, got.cluster_index, got.bin_fraction,
				got.last_of_cell);
		end else begin
			want = expected_bins.pop_front();
			if (got.cell_number !== want.cell_number
					|| got.cluster_index !== want.cluster_index
					|| got.bin_fraction !== want.bin_fraction
					|| got.last_of_cell !== want.last_of_cell) begin
				error_count++;
				$display("%0t: mismatch expected cell %0d cluster %0d fraction %0d last %0b",
					$time, want.cell_number, want.cluster_index, want.bin_fraction,
					want.last_of_cell);
				$display("%0t:          actual   cell %0d cluster %0d fraction %0d last %0b",
					$time, got.cell_number, got.cluster_index, got.bin_fraction,
					got.last_of_cell);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			check_result(result);
		pop <= !rx_hold && ($urandom_range(99) >= stall_pct);
	end

	// called at a clock edge; returns at the edge where the request is taken
	task automatic send_pixel(lncch_pkg::pixel_t px);
		if ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(24, 1)) @(posedge clk);
		end
		push <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (full) begin
			full_cycles++;
			@(posedge clk);
		end
		predict_pixel(px);
		pixels_sent++;
	endtask

	task automatic test_directed();
		lncch_pkg::pixel_t px;
		idle_pct = 0;
		stall_pct = 0;
		for (int k = 0; k < NUM_COLORS; k++) begin
			px.lightness = 8'((COLOR_CENTERS[k][0] + 128) / 256);
			px.chroma_a  = 8'((COLOR_CENTERS[k][1] + 128) / 256);
			px.chroma_b  = 8'((COLOR_CENTERS[k][2] + 128) / 256);
			send_pixel(px);
		end
		for (int m = 0; m < 8; m++) begin
			px.lightness = m[0] ? 8'hff : 8'h00;
			px.chroma_a  = m[1] ? 8'hff : 8'h00;
			px.chroma_b  = m[2] ? 8'hff : 8'h00;
			send_pixel(px);
		end
		send_pixel('{lightness: 8'd128, chroma_a: 8'd128, chroma_b: 8'd128});
	endtask

	// look for a pixel exactly between two centroids where the pair is nearest
	task automatic test_tie();
		lncch_pkg::pixel_t px;
		longint rhs;
		longint plane;
		longint num;
		longint d [3];
		longint bv;
		int found;
		found = 0;
		for (int j = 0; j < NUM_COLORS && found == 0; j++) begin
			for (int k = j + 1; k < NUM_COLORS && found == 0; k++) begin
				rhs = 0;
				for (int c = 0; c < 3; c++) begin
					d[c] = COLOR_CENTERS[k][c] - COLOR_CENTERS[j][c];
					rhs += longint'(COLOR_CENTERS[k][c]) * COLOR_CENTERS[k][c]
						- longint'(COLOR_CENTERS[j][c]) * COLOR_CENTERS[j][c];
				end
				if (rhs % 512 == 0 && d[2] != 0) begin
					plane = rhs / 512;
					for (int l = 0; l < 256 && found == 0; l++) begin
						for (int a = 0; a < 256 && found == 0; a++) begin
							num = plane - l * d[0] - a * d[1];
							if (num % d[2] == 0) begin
								bv = num / d[2];
								if (bv >= 0 && bv <= 255) begin
									px.lightness = 8'(l);
									px.chroma_a  = 8'(a);
									px.chroma_b  = 8'(bv);
									if (nearest_color(px) == j)
										found = 1;
								end
							end
						end
					end
				end
			end
		end
		if (found != 0) begin
			send_pixel(px);
			ties_sent++;
		end
	endtask

	task automatic test_random(int count, int sender_idle, int receiver_stall);
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		repeat (count) send_pixel(random_pixel());
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (48) send_pixel(random_pixel());
	endtask

	// whole cells, some filled with a single color so one bin takes the full share
	task automatic test_solid_cells(int cells);
		lncch_pkg::pixel_t px;
		bit same_color;
		idle_pct = 0;
		stall_pct = 0;
		px = random_pixel();
		same_color = 1'b1;
		while (pixels_in_cell != 0)
			send_pixel(random_pixel());
		repeat (cells * AREA) begin
			if (pixels_in_cell == 0) begin
				px = random_pixel();
				same_color = $urandom_range(1);
			end
			send_pixel(same_color ? px : random_pixel());
		end
	endtask

	task automatic finish_run();
		push <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		while (expected_bins.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int hit_colors;
		hit_colors = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_tie();
		test_random(64, 0, 0);
		test_random(64, 46, 0);
		test_random(64, 0, 46);
		test_random(64, 34, 34);
		test_backpressure();
		test_solid_cells(2);
		finish_run();
		for (int k = 0; k < NUM_COLORS; k++)
			if (color_hits[k] != 0)
				hit_colors++;
		$display("Sent %0d pixels (%0d exact ties), checked %0d histogram results",
			pixels_sent, ties_sent, results_seen);
		$display("Centroids chosen: %0d of %0d; input held off by full for %0d cycles",
			hit_colors, NUM_COLORS, full_cycles);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
